>>> rtl/pal_pkg.sv
// Package: action and status codes and the per-cell control word of the positional list.
`timescale 1ns / 1ps

package pal_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int POS_BITS       = 7;
    localparam int COUNT_OUT_BITS = 8;
    localparam int RD_GROUP       = 16;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Broadcast to every cell in the accept cycle.
    typedef struct packed {
        logic ins;   // open a slot at the position and write the new word there
        logic del;   // close the slot at the position
        logic rd;    // present the word at the position to the read tree
    } t_cell_ctrl;

endpackage

>>> rtl/pal_cell.sv
// Module: one storage cell of the list; shifts with its neighbours on insert and delete.
`timescale 1ns / 1ps

module pal_cell #(
    parameter int WORD_BITS = 32,
    parameter int PW        = 8,
    parameter int IDX       = 0
) (
    input  logic                  i_clk,
    input  pal_pkg::t_cell_ctrl   i_ctrl,
    input  logic [PW-1:0]         i_pos,
    input  logic [WORD_BITS-1:0]  i_new_word,
    input  logic [WORD_BITS-1:0]  i_left_word,
    input  logic [WORD_BITS-1:0]  i_right_word,
    output logic [WORD_BITS-1:0]  o_word,
    output logic [WORD_BITS-1:0]  o_rd_word
);
    import pal_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;
    logic                 w_here;
    logic                 w_above;

    assign w_here  = (MY_IDX == i_pos);
    assign w_above = (MY_IDX > i_pos);

    always_comb begin
        n_word = r_word;
        if (i_ctrl.ins) begin
            if (w_here) begin
                n_word = i_new_word;
            end else if (w_above) begin
                n_word = i_left_word;
            end
        end else if (i_ctrl.del) begin
            if (w_here || w_above) begin
                n_word = i_right_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word    = r_word;
    // old word, sampled by the read tree before any shift lands
    assign o_rd_word = (i_ctrl.rd && w_here) ? r_word : '0;

endmodule

>>> rtl/pal_rdtree.sv
// Module: two-level registered OR tree that collects the one selected cell word.
`timescale 1ns / 1ps

module pal_rdtree #(
    parameter int WORD_BITS = 32,
    parameter int CAPACITY  = 128
) (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic [WORD_BITS-1:0] i_words [CAPACITY],
    output logic [WORD_BITS-1:0] o_word
);
    import pal_pkg::*;

    localparam int NGRP = (CAPACITY + RD_GROUP - 1) / RD_GROUP;
    localparam int NPAD = NGRP * RD_GROUP;

    logic [WORD_BITS-1:0] w_pad [NPAD];
    logic [WORD_BITS-1:0] n_grp [NGRP];
    logic [WORD_BITS-1:0] r_grp [NGRP];

    genvar gi;
    generate
        for (gi = 0; gi < NPAD; gi++) begin : g_pad
            if (gi < CAPACITY) begin : g_live
                assign w_pad[gi] = i_words[gi];
            end else begin : g_zero
                assign w_pad[gi] = '0;
            end
        end
    endgenerate

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < RD_GROUP; k++) begin
                n_grp[g] = n_grp[g] | w_pad[g * RD_GROUP + k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= n_grp;
        end
    end

    always_comb begin
        o_word = '0;
        for (int g = 0; g < NGRP; g++) begin
            o_word = o_word | r_grp[g];
        end
    end

endmodule

>>> rtl/positional_array_list_top.sv
// Top level: positional list of signed words held in a row of shifting cells.
`timescale 1ns / 1ps
// Use of the block
// - Input channel (i_in_valid / o_in_stall) carries one request word: an action
//   (insert at position, append, delete at position, read at position), a
//   position and a signed value. Output channel (o_out_valid / i_out_stall)
//   returns exactly one result word per request: the value read or removed,
//   a status (ok, position out of range, list full), the entry count after
//   the action and the empty and full flags.
// - Every cell updates in the accept cycle, so the list shifts as a whole and
//   the next request sees it at once. The selected word is gathered by a
//   two-level OR tree: first level registered in the accept cycle, second
//   level feeding the output register as the tree stage advances.
// - Throughput: one request per cycle while the output side takes results;
//   the tree register is the one stage between the cells and the output
//   register.
// - Reset (i_rst_n low at a clock edge) empties the list and drops anything in
//   flight; cell contents are not cleared and only entries below the count
//   are ever read back.
// - When the receiver stalls, the result holds in the output register, one
//   more result waits in the tree stage, and then o_in_stall rises.
module positional_array_list_top #(
    parameter int CAPACITY  = 128,
    parameter int WORD_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_action,
    input  logic [pal_pkg::POS_BITS-1:0]          i_position,
    input  logic signed [pal_pkg::VALUE_BITS-1:0] i_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [pal_pkg::VALUE_BITS-1:0] o_read_value,
    output logic [1:0]                            o_status,
    output logic [pal_pkg::COUNT_OUT_BITS-1:0]    o_entry_count,
    output logic                                  o_list_empty,
    output logic                                  o_list_full
);
    import pal_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // handshake
    logic w_in_acc;
    logic w_adv;
    logic w_out_acc;

    // list control
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    t_cell_ctrl      w_ctrl;
    t_status         w_status;
    logic [CMPW-1:0] w_pos_x;
    logic [CMPW-1:0] w_cnt_x;
    logic [CMPW-1:0] w_eff_pos;
    logic            w_is_full;

    logic signed [WORD_BITS-1:0] w_new_word;
    logic [WORD_BITS-1:0]        w_word    [CAPACITY];
    logic [WORD_BITS-1:0]        w_rd_word [CAPACITY];
    logic [WORD_BITS-1:0]        w_tree_word;

    // tree stage
    logic          r_a_valid;
    t_status       r_a_status;
    logic [CW-1:0] r_a_count;

    // output register
    logic                          r_out_valid;
    logic signed [VALUE_BITS-1:0]  r_out_value;
    t_status                       r_out_status;
    logic [CW-1:0]                 r_out_count;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = r_out_valid && !i_out_stall;
    assign w_adv      = r_a_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_a_valid && !w_adv;

    assign w_pos_x    = CMPW'(i_position);
    assign w_cnt_x    = CMPW'(r_count);
    assign w_is_full  = (r_count == CAP_CNT);
    assign w_new_word = WORD_BITS'(i_value);

    // decode the request; append is an insert at the current count
    always_comb begin
        w_ctrl    = '0;
        w_status  = ST_OK;
        w_eff_pos = w_pos_x;
        n_count   = r_count;
        case (t_action'(i_action))
            ACT_INSERT: begin
                if (w_is_full) begin
                    w_status = ST_FULL;
                end else if (w_pos_x > w_cnt_x) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.ins = 1'b1;
                    n_count    = r_count + CW'(1);
                end
            end
            ACT_APPEND: begin
                w_eff_pos = w_cnt_x;
                if (w_is_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.ins = 1'b1;
                    n_count    = r_count + CW'(1);
                end
            end
            ACT_DELETE: begin
                if (w_pos_x >= w_cnt_x) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.rd  = 1'b1;
                    w_ctrl.del = 1'b1;
                    n_count    = r_count - CW'(1);
                end
            end
            ACT_READ: begin
                if (w_pos_x >= w_cnt_x) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.rd = 1'b1;
                end
            end
            default: begin
                w_status = ST_RANGE;
            end
        endcase
        // nothing moves unless a word is taken
        if (!w_in_acc) begin
            w_ctrl  = '0;
            n_count = r_count;
        end
    end

    // row of cells; end cells take their own word as the missing neighbour
    genvar ci;
    generate
        for (ci = 0; ci < CAPACITY; ci++) begin : g_cell
            logic [WORD_BITS-1:0] w_left;
            logic [WORD_BITS-1:0] w_right;
            if (ci == 0) begin : g_first
                assign w_left = w_word[ci];
            end else begin : g_mid_l
                assign w_left = w_word[ci-1];
            end
            if (ci == CAPACITY - 1) begin : g_last
                assign w_right = w_word[ci];
            end else begin : g_mid_r
                assign w_right = w_word[ci+1];
            end
            pal_cell #(
                .WORD_BITS (WORD_BITS),
                .PW        (CMPW),
                .IDX       (ci)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_pos        (w_eff_pos),
                .i_new_word   (w_new_word),
                .i_left_word  (w_left),
                .i_right_word (w_right),
                .o_word       (w_word[ci]),
                .o_rd_word    (w_rd_word[ci])
            );
        end
    endgenerate

    pal_rdtree #(
        .WORD_BITS (WORD_BITS),
        .CAPACITY  (CAPACITY)
    ) u_rdtree (
        .i_clk   (i_clk),
        .i_load  (w_in_acc),
        .i_words (w_rd_word),
        .o_word  (w_tree_word)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_in_acc) begin
                r_a_valid <= 1'b1;
            end else if (w_adv) begin
                r_a_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: hold the tree stage and the result while stalled
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_status <= w_status;
            r_a_count  <= n_count;
        end
        if (w_adv) begin
            r_out_value  <= VALUE_BITS'(signed'(w_tree_word));
            r_out_status <= r_a_status;
            r_out_count  <= r_a_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_out_value;
    assign o_status      = r_out_status;
    assign o_entry_count = COUNT_OUT_BITS'(r_out_count);
    assign o_list_empty  = (r_out_count == '0);
    assign o_list_full   = (r_out_count == CAP_CNT);

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("entry count beyond capacity");

    a_ctrl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_ctrl.ins, w_ctrl.rd}) && (!w_ctrl.del || w_ctrl.rd))
        else $error("conflicting cell controls");

    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> $stable(r_count))
        else $error("count moved without an accepted word");

    a_err_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_status != ST_OK)) |=> $stable(r_count))
        else $error("rejected request changed the count");

    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.ins |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list by one");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !w_adv) |=> (r_a_valid && $stable(r_a_count)))
        else $error("tree stage lost its word while blocked");

endmodule
